// File: sv/cste_pkg.sv
`timescale 1ns / 1ps
package cste_pkg;

    localparam int QW = 48;
    localparam int MAC_LAT = 5;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    localparam logic [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

    typedef struct packed {
        logic          func;
        logic [5:0]    entry_index;
        logic [QW-1:0] knot_position;
        logic [QW-1:0] knot_value;
        logic [QW-1:0] linear_coef;
        logic [QW-1:0] quadratic_coef;
        logic [QW-1:0] cubic_coef;
        logic [QW-1:0] query_point;
    } cste_req_t;

    typedef struct packed {
        logic [QW-1:0] interpolated_value;
        logic [5:0]    interval_used;
        logic          from_query;
        logic          saturated;
    } cste_rsp_t;

    typedef struct packed {
        logic       valid;
        logic       from_query;
        logic [5:0] interval;
    } cste_tag_t;

    // clamp a 49-bit sum to 48 bits; top bit of the result flags a clamp
    function automatic logic [QW:0] clamp49(logic [QW:0] s);
        logic [QW:0] r;
        if (s[QW] != s[QW-1])
        begin
            r = {1'b1, (s[QW] ? Q_MIN : Q_MAX)};
        end
        else
        begin
            r = {1'b0, s[QW-1:0]};
        end
        return r;
    endfunction

endpackage

// File: sv/cste_ram.sv
`timescale 1ns / 1ps
module cste_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/cste_mac.sv
`timescale 1ns / 1ps
module cste_mac (
    input  logic                  clk,
    input  logic                  en,
    input  logic [cste_pkg::QW-1:0] a,
    input  logic [cste_pkg::QW-1:0] b,
    input  logic [cste_pkg::QW-1:0] addend,
    input  logic                  sat_in,
    output logic [cste_pkg::QW-1:0] result,
    output logic                  sat_out
);
    import cste_pkg::*;

    localparam int HW = QW / 2;
    localparam int PW = 2 * QW;

    logic [QW-1:0] am_reg, bm_reg, add1_reg;
    logic          neg1_reg, sat1_reg;
    logic [QW-1:0] ll_reg, lh_reg, hl_reg, hh_reg, add2_reg;
    logic          neg2_reg, sat2_reg;
    logic [PW-1:0] mag_reg;
    logic [QW-1:0] add3_reg;
    logic          neg3_reg, sat3_reg;
    logic [PW:0]   rnd_reg;
    logic [QW-1:0] add4_reg;
    logic          sat4_reg;
    logic [QW-1:0] result_reg;
    logic          sat_reg;

    logic [PW:0]   rnd_next;
    logic          ovf;
    logic [QW-1:0] prod;
    logic [QW:0]   sum_cl;

    always_comb
    begin
        if (neg3_reg)
        begin
            rnd_next = (PW + 1)'(0) - {1'b0, mag_reg} + ((PW + 1)'(1) << (HW - 1));
        end
        else
        begin
            rnd_next = {1'b0, mag_reg} + ((PW + 1)'(1) << (HW - 1));
        end
    end

    always_comb
    begin
        ovf  = !((&rnd_reg[PW:PW-HW-1]) || !(|rnd_reg[PW:PW-HW-1]));
        prod = ovf ? (rnd_reg[PW] ? Q_MIN : Q_MAX) : rnd_reg[QW+HW-1:HW];
        sum_cl = clamp49({add4_reg[QW-1], add4_reg} + {prod[QW-1], prod});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            am_reg   <= a[QW-1] ? QW'(-a) : a;
            bm_reg   <= b[QW-1] ? QW'(-b) : b;
            neg1_reg <= a[QW-1] ^ b[QW-1];
            add1_reg <= addend;
            sat1_reg <= sat_in;

            ll_reg   <= QW'(am_reg[HW-1:0] * bm_reg[HW-1:0]);
            lh_reg   <= QW'(am_reg[HW-1:0] * bm_reg[QW-1:HW]);
            hl_reg   <= QW'(am_reg[QW-1:HW] * bm_reg[HW-1:0]);
            hh_reg   <= QW'(am_reg[QW-1:HW] * bm_reg[QW-1:HW]);
            neg2_reg <= neg1_reg;
            add2_reg <= add1_reg;
            sat2_reg <= sat1_reg;

            mag_reg  <= {hh_reg, {QW{1'b0}}} + {{HW{1'b0}}, lh_reg, {HW{1'b0}}}
                      + {{HW{1'b0}}, hl_reg, {HW{1'b0}}} + {{QW{1'b0}}, ll_reg};
            neg3_reg <= neg2_reg;
            add3_reg <= add2_reg;
            sat3_reg <= sat2_reg;

            rnd_reg  <= rnd_next;
            add4_reg <= add3_reg;
            sat4_reg <= sat3_reg;

            result_reg <= sum_cl[QW-1:0];
            sat_reg    <= sat4_reg | ovf | sum_cl[QW];
        end
    end

    assign result  = result_reg;
    assign sat_out = sat_reg;

endmodule

// File: sv/cubic_spline_table_evaluator.sv
`timescale 1ns / 1ps
// cubic spline table evaluator
// query channel (query_valid / query_stall / query) carries one item per
// transfer: func 0 writes knot entry entry_index, func 1 evaluates the spline
// at query_point. every item gives exactly one transfer on the result channel
// (result_valid / result_stall / result), in order; writes return zeros with
// from_query 0.
// knot_count is written with knot_count_we, which the user must only do while
// no item is in flight, unenforced by the block; it is clamped to 2..MAX_KNOTS.
// the search has one binary search level per stage, each with its own copy
// of the position table, then a table read, the offset subtract and three
// five-stage multiply-add units.
// one item per cycle is accepted while the result side is not stalled.
// when result_stall holds a waiting result the whole pipeline freezes and
// query_stall rises; nothing is lost or repeated.
// reset clears the valid bits and sets knot_count to min(MAX_KNOTS, 64); the
// knot tables are not cleared and must be written before they are searched.
module cubic_spline_table_evaluator #(
    parameter int MAX_KNOTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                query_valid,
    output logic                query_stall,
    input  cste_pkg::cste_req_t query,
    output logic                result_valid,
    input  logic                result_stall,
    output cste_pkg::cste_rsp_t result,
    input  logic                knot_count_we,
    input  logic [6:0]          knot_count
);
    import cste_pkg::*;

    localparam int AW = $clog2(MAX_KNOTS);
    localparam int NW = $clog2(MAX_KNOTS + 1);
    localparam int L  = AW;
    localparam int TL = 3 * MAC_LAT;

    logic adv;
    logic [NW-1:0] n_reg;

    cste_req_t     s_req_reg   [0:L];
    logic [NW-1:0] s_lo_reg    [0:L];
    logic [NW-1:0] s_hi_reg    [0:L];
    logic          s_le_reg    [0:L];
    logic          s_ge_reg    [0:L];
    logic          s_valid_reg [0:L];

    logic [NW-1:0] eff_lo [0:L];
    logic [NW-1:0] eff_hi [0:L];
    logic          eff_le [0:L];
    logic          eff_ge [0:L];
    logic          wr_ok  [0:L];
    logic [QW-1:0] lvl_rdata [0:L-1];
    logic [QW-1:0] e0_rdata, e1_rdata;

    logic [AW-1:0] sel_i;
    logic [QW-1:0] c_pos, c_val, c_lin, c_quad, c_cub;
    cste_tag_t     c_tag_reg;
    logic [QW-1:0] c_query_reg;
    logic [QW:0]   z_cl;

    cste_tag_t     d_tag_reg;
    logic [QW-1:0] d_z_reg, d_y_reg, d_b_reg, d_c_reg, d_d_reg;
    logic          d_zsat_reg;

    logic [QW-1:0] z_dly_reg [0:2*MAC_LAT-1];
    logic [QW-1:0] y_dly_reg [0:2*MAC_LAT-1];
    logic [QW-1:0] b_dly_reg [0:MAC_LAT-1];
    cste_tag_t     tag_dly_reg [0:TL-1];

    logic [QW-1:0] p_val, q_val, r_val;
    logic          p_sat, q_sat, r_sat;

    cste_rsp_t result_reg;
    logic      result_valid_reg;

    assign adv          = !(result_valid_reg && result_stall);
    assign query_stall  = !adv;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= NW'(MAX_KNOTS < 64 ? MAX_KNOTS : 64);
        end
        else if (knot_count_we)
        begin
            if (knot_count < 7'd2)
            begin
                n_reg <= NW'(2);
            end
            else if (32'(knot_count) > MAX_KNOTS)
            begin
                n_reg <= NW'(MAX_KNOTS);
            end
            else
            begin
                n_reg <= NW'(knot_count);
            end
        end
    end

    // search stages
    genvar j;
    generate
        for (j = 0; j <= L; j++)
        begin : g_lvl
            assign wr_ok[j] = adv && s_valid_reg[j] && (s_req_reg[j].func == FUNC_WRITE)
                              && ((32'(s_req_reg[j].entry_index)) < MAX_KNOTS);
            if (j == 0)
            begin : g_first
                assign eff_lo[j] = s_lo_reg[j];
                assign eff_hi[j] = s_hi_reg[j];
                assign eff_le[j] = 1'b0;
                assign eff_ge[j] = 1'b0;
            end
            else
            begin : g_upd
                logic [NW-1:0] mid_prev;
                logic          go;
                logic          lt;
                assign mid_prev = NW'(({1'b0, s_lo_reg[j]} + {1'b0, s_hi_reg[j]}) >> 1);
                assign go = (s_hi_reg[j] - s_lo_reg[j]) > NW'(1);
                assign lt = $signed(s_req_reg[j].query_point) < $signed(lvl_rdata[j-1]);
                assign eff_lo[j] = (go && !lt) ? mid_prev : s_lo_reg[j];
                assign eff_hi[j] = (go && lt) ? mid_prev : s_hi_reg[j];
                if (j == 1)
                begin : g_edge
                    assign eff_le[j] = $signed(s_req_reg[j].query_point) <= $signed(e0_rdata);
                    assign eff_ge[j] = $signed(s_req_reg[j].query_point) >= $signed(e1_rdata);
                end
                else
                begin : g_keep
                    assign eff_le[j] = s_le_reg[j];
                    assign eff_ge[j] = s_ge_reg[j];
                end
            end
            if (j < L)
            begin : g_ram
                logic [AW-1:0] mid;
                assign mid = AW'(({1'b0, eff_lo[j]} + {1'b0, eff_hi[j]}) >> 1);
                cste_ram #(.WIDTH(QW), .DEPTH(MAX_KNOTS)) u_pos (
                    .clk   (clk),
                    .we    (wr_ok[j]),
                    .waddr (AW'(s_req_reg[j].entry_index)),
                    .wdata (s_req_reg[j].knot_position),
                    .re    (adv),
                    .raddr (mid),
                    .rdata (lvl_rdata[j])
                );
            end
        end
    endgenerate

    cste_ram #(.WIDTH(QW), .DEPTH(MAX_KNOTS)) u_first (
        .clk   (clk),
        .we    (wr_ok[0]),
        .waddr (AW'(s_req_reg[0].entry_index)),
        .wdata (s_req_reg[0].knot_position),
        .re    (adv),
        .raddr (AW'(0)),
        .rdata (e0_rdata)
    );

    cste_ram #(.WIDTH(QW), .DEPTH(MAX_KNOTS)) u_last (
        .clk   (clk),
        .we    (wr_ok[0]),
        .waddr (AW'(s_req_reg[0].entry_index)),
        .wdata (s_req_reg[0].knot_position),
        .re    (adv),
        .raddr (AW'(n_reg - NW'(2))),
        .rdata (e1_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= L; k++)
            begin
                s_valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s_valid_reg[0] <= query_valid;
            for (int k = 1; k <= L; k++)
            begin
                s_valid_reg[k] <= s_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_req_reg[0] <= query;
            s_lo_reg[0]  <= '0;
            s_hi_reg[0]  <= n_reg;
            s_le_reg[0]  <= 1'b0;
            s_ge_reg[0]  <= 1'b0;
            for (int k = 1; k <= L; k++)
            begin
                s_req_reg[k] <= s_req_reg[k-1];
                s_lo_reg[k]  <= eff_lo[k-1];
                s_hi_reg[k]  <= eff_hi[k-1];
                s_le_reg[k]  <= eff_le[k-1];
                s_ge_reg[k]  <= eff_ge[k-1];
            end
        end
    end

    // interval select and coefficient read
    always_comb
    begin
        if (eff_le[L])
        begin
            sel_i = '0;
        end
        else if (eff_ge[L])
        begin
            sel_i = AW'(n_reg - NW'(2));
        end
        else
        begin
            sel_i = AW'(eff_lo[L]);
        end
    end

    cste_ram #(.WIDTH(QW), .DEPTH(MAX_KNOTS)) u_xi (
        .clk (clk), .we (wr_ok[L]), .waddr (AW'(s_req_reg[L].entry_index)),
        .wdata (s_req_reg[L].knot_position), .re (adv), .raddr (sel_i), .rdata (c_pos)
    );
    cste_ram #(.WIDTH(QW), .DEPTH(MAX_KNOTS)) u_y (
        .clk (clk), .we (wr_ok[L]), .waddr (AW'(s_req_reg[L].entry_index)),
        .wdata (s_req_reg[L].knot_value), .re (adv), .raddr (sel_i), .rdata (c_val)
    );
    cste_ram #(.WIDTH(QW), .DEPTH(MAX_KNOTS)) u_b (
        .clk (clk), .we (wr_ok[L]), .waddr (AW'(s_req_reg[L].entry_index)),
        .wdata (s_req_reg[L].linear_coef), .re (adv), .raddr (sel_i), .rdata (c_lin)
    );
    cste_ram #(.WIDTH(QW), .DEPTH(MAX_KNOTS)) u_c (
        .clk (clk), .we (wr_ok[L]), .waddr (AW'(s_req_reg[L].entry_index)),
        .wdata (s_req_reg[L].quadratic_coef), .re (adv), .raddr (sel_i), .rdata (c_quad)
    );
    cste_ram #(.WIDTH(QW), .DEPTH(MAX_KNOTS)) u_d (
        .clk (clk), .we (wr_ok[L]), .waddr (AW'(s_req_reg[L].entry_index)),
        .wdata (s_req_reg[L].cubic_coef), .re (adv), .raddr (sel_i), .rdata (c_cub)
    );

    assign z_cl = clamp49({c_query_reg[QW-1], c_query_reg} - {c_pos[QW-1], c_pos});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_tag_reg <= '0;
            d_tag_reg <= '0;
            for (int k = 0; k < TL; k++)
            begin
                tag_dly_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            c_tag_reg.valid      <= s_valid_reg[L];
            c_tag_reg.from_query <= s_req_reg[L].func;
            c_tag_reg.interval   <= 6'(sel_i);
            d_tag_reg            <= c_tag_reg;
            tag_dly_reg[0]       <= d_tag_reg;
            for (int k = 1; k < TL; k++)
            begin
                tag_dly_reg[k] <= tag_dly_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_query_reg <= s_req_reg[L].query_point;
            d_z_reg     <= z_cl[QW-1:0];
            d_zsat_reg  <= z_cl[QW];
            d_y_reg     <= c_val;
            d_b_reg     <= c_lin;
            d_c_reg     <= c_quad;
            d_d_reg     <= c_cub;
            z_dly_reg[0] <= d_z_reg;
            y_dly_reg[0] <= d_y_reg;
            b_dly_reg[0] <= d_b_reg;
            for (int k = 1; k < 2 * MAC_LAT; k++)
            begin
                z_dly_reg[k] <= z_dly_reg[k-1];
                y_dly_reg[k] <= y_dly_reg[k-1];
            end
            for (int k = 1; k < MAC_LAT; k++)
            begin
                b_dly_reg[k] <= b_dly_reg[k-1];
            end
        end
    end

    // horner steps
    cste_mac u_mac_p (
        .clk (clk), .en (adv), .a (d_d_reg), .b (d_z_reg), .addend (d_c_reg),
        .sat_in (d_zsat_reg), .result (p_val), .sat_out (p_sat)
    );
    cste_mac u_mac_q (
        .clk (clk), .en (adv), .a (p_val), .b (z_dly_reg[MAC_LAT-1]),
        .addend (b_dly_reg[MAC_LAT-1]), .sat_in (p_sat), .result (q_val), .sat_out (q_sat)
    );
    cste_mac u_mac_r (
        .clk (clk), .en (adv), .a (q_val), .b (z_dly_reg[2*MAC_LAT-1]),
        .addend (y_dly_reg[2*MAC_LAT-1]), .sat_in (q_sat), .result (r_val), .sat_out (r_sat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= tag_dly_reg[TL-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (tag_dly_reg[TL-1].from_query == FUNC_EVAL)
            begin
                result_reg.interpolated_value <= r_val;
                result_reg.interval_used      <= tag_dly_reg[TL-1].interval;
                result_reg.from_query         <= 1'b1;
                result_reg.saturated          <= r_sat;
            end
            else
            begin
                result_reg <= '0;
            end
        end
    end

endmodule
